### sv/particle_sensor_frame_parser_core_defines.svh
// Assertion macros shared by the frame parser modules.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_CORE_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PSFP_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("psfp assertion failed");
`define PSFP_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("psfp assertion failed");
`else
`define PSFP_ASSERT_IMP(lbl, ant, cons)
`define PSFP_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

### sv/psfp_pkg.sv
// Types and constants shared by the frame parser modules.
package psfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;
  localparam logic [15:0] LEN_SHORT = 16'd28;
  localparam logic [15:0] LEN_LONG  = 16'd36;
  localparam int WORDS_SHORT = 13;
  localparam int WORDS_LONG  = 15;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_LEN_ERR = 2'd1;
  localparam logic [1:0] STAT_CHK_ERR = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       env;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [15:0] data;
  } wr_t;

endpackage

### sv/psfp_front.sv
// Byte parser: header hunt, length check, word capture, checksum and command issue.
`include "particle_sensor_frame_parser_core_defines.svh"
module psfp_front #(
  parameter int MAX_WORDS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            run_done,
  input  logic            q_full,
  output logic            q_push,
  output psfp_pkg::cmd_t  q_cmd,
  output psfp_pkg::wr_t   wr
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHKHI = 3'd5;
  localparam logic [2:0] PH_CHKLO = 3'd6;

  localparam int CNT_S = (MAX_WORDS < psfp_pkg::WORDS_SHORT) ? MAX_WORDS : psfp_pkg::WORDS_SHORT;
  localparam int CNT_L = (MAX_WORDS < psfp_pkg::WORDS_LONG) ? MAX_WORDS : psfp_pkg::WORDS_LONG;
  localparam logic [4:0] MAXW = 5'(MAX_WORDS);

  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  bc_r, bc_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        busy_r, busy_nxt;

  logic        acc;
  logic        stall;
  logic [15:0] sum_add;
  logic [15:0] pair;
  logic        env;

  always_comb begin
    stall = ((phase_r == PH_DATA) && busy_r) ||
            (((phase_r == PH_LENLO) || (phase_r == PH_CHKLO)) && q_full);
    in_ready = !stall;
    acc = in_valid && in_ready;
    sum_add = sum_r + {8'h00, in_rx_byte};
    pair = {hold_r, in_rx_byte};
    env = ({10'd0, len_r} == psfp_pkg::LEN_LONG);

    phase_nxt = phase_r;
    bc_nxt = bc_r;
    len_nxt = len_r;
    sum_nxt = sum_r;
    hold_nxt = hold_r;
    busy_nxt = busy_r & ~run_done;
    q_push = 1'b0;
    q_cmd = '0;
    wr = '0;

    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == psfp_pkg::HDR_FIRST) begin
            phase_nxt = PH_HDR2;
            sum_nxt = {8'h00, psfp_pkg::HDR_FIRST};
          end
        end
        PH_HDR2: begin
          if (in_rx_byte == psfp_pkg::HDR_SECOND) begin
            sum_nxt = sum_add;
            phase_nxt = PH_LENHI;
          end else if (in_rx_byte == psfp_pkg::HDR_FIRST) begin
            sum_nxt = {8'h00, psfp_pkg::HDR_FIRST};
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LENHI: begin
          hold_nxt = in_rx_byte;
          sum_nxt = sum_add;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          sum_nxt = sum_add;
          if ((pair == psfp_pkg::LEN_SHORT) || (pair == psfp_pkg::LEN_LONG)) begin
            len_nxt = pair[5:0];
            bc_nxt = '0;
            phase_nxt = PH_DATA;
          end else begin
            q_push = 1'b1;
            q_cmd.status = psfp_pkg::STAT_LEN_ERR;
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_nxt = sum_add;
          if (!bc_r[0]) begin
            hold_nxt = in_rx_byte;
          end else if (bc_r[5:1] < MAXW) begin
            wr.en = 1'b1;
            wr.addr = bc_r[4:1];
            wr.data = pair;
          end
          bc_nxt = bc_r + 6'd1;
          if (({1'b0, bc_nxt} + 7'd2) >= {1'b0, len_r}) begin
            phase_nxt = PH_CHKHI;
          end
        end
        PH_CHKHI: begin
          hold_nxt = in_rx_byte;
          phase_nxt = PH_CHKLO;
        end
        PH_CHKLO: begin
          q_push = 1'b1;
          q_cmd.env = env;
          if (pair == sum_r) begin
            q_cmd.status = psfp_pkg::STAT_OK;
            q_cmd.cnt = env ? 4'(CNT_L) : 4'(CNT_S);
            busy_nxt = 1'b1;
          end else begin
            q_cmd.status = psfp_pkg::STAT_CHK_ERR;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      bc_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      hold_r <= '0;
      busy_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bc_r <= bc_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      hold_r <= hold_nxt;
      busy_r <= busy_nxt;
    end
  end

  `PSFP_ASSERT_IMP(a_no_write_while_draining, wr.en, !busy_r)
  `PSFP_ASSERT_NXT(a_run_marks_busy, q_push && (q_cmd.status == psfp_pkg::STAT_OK), busy_r)

endmodule

### sv/psfp_cmd_fifo.sv
// Two-entry command queue between the byte parser and the result sequencer.
`include "particle_sensor_frame_parser_core_defines.svh"
module psfp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psfp_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output psfp_pkg::cmd_t dout
);

  psfp_pkg::cmd_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full = (cnt_r == 2'd2);
    nonempty = (cnt_r != 2'd0);
    dout = mem_r[rp_r];
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `PSFP_ASSERT_IMP(a_no_push_when_full, push, !full)

endmodule

### sv/psfp_back.sv
// Result sequencer: word store and output register, drains one command at a time.
`include "particle_sensor_frame_parser_core_defines.svh"
module psfp_back #(
  parameter int MAX_WORDS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  psfp_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  input  psfp_pkg::wr_t   wr,
  output logic            run_done,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_word_index,
  output logic [15:0]     out_word_value,
  output logic [1:0]      out_frame_status,
  output logic            out_has_env,
  output logic            out_last
);

  localparam int AW = $clog2(MAX_WORDS);

  logic [15:0] mem_r [MAX_WORDS];

  logic       run_r, run_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       env_r, env_nxt;
  logic       ov_r, ov_nxt;

  logic [3:0]  oidx_r;
  logic [15:0] oval_r;
  logic [1:0]  ostat_r;
  logic        oenv_r;
  logic        olast_r;

  logic slot_free;
  logic load_word;
  logic last_word;
  logic pop_err;

  always_comb begin
    slot_free = !ov_r || out_ready;
    load_word = run_r && slot_free;
    last_word = (idx_r == (cnt_r - 4'd1));
    q_pop = !run_r && slot_free && q_nonempty;
    pop_err = q_pop && (q_cmd.status != psfp_pkg::STAT_OK);
    run_done = load_word && last_word;

    run_nxt = run_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    env_nxt = env_r;
    ov_nxt = ov_r && !out_ready;

    if (load_word) begin
      ov_nxt = 1'b1;
      idx_nxt = idx_r + 4'd1;
      if (last_word) begin
        run_nxt = 1'b0;
      end
    end else if (pop_err) begin
      ov_nxt = 1'b1;
    end else if (q_pop) begin
      run_nxt = 1'b1;
      idx_nxt = '0;
      cnt_nxt = q_cmd.cnt;
      env_nxt = q_cmd.env;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr[AW-1:0]] <= wr.data;
    end
    if (load_word) begin
      oval_r <= mem_r[idx_r[AW-1:0]];
      oidx_r <= idx_r;
      ostat_r <= psfp_pkg::STAT_OK;
      oenv_r <= env_r;
      olast_r <= last_word;
    end else if (pop_err) begin
      oval_r <= '0;
      oidx_r <= '0;
      ostat_r <= q_cmd.status;
      oenv_r <= q_cmd.env;
      olast_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
      cnt_r <= '0;
      env_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      env_r <= env_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_word_index = oidx_r;
  assign out_word_value = oval_r;
  assign out_frame_status = ostat_r;
  assign out_has_env = oenv_r;
  assign out_last = olast_r;

  `PSFP_ASSERT_IMP(a_error_is_single, ov_r && (ostat_r != psfp_pkg::STAT_OK),
    olast_r && (oidx_r == 4'd0) && (oval_r == 16'd0))
  `PSFP_ASSERT_IMP(a_last_word_index, ov_r && (ostat_r == psfp_pkg::STAT_OK) && olast_r,
    oidx_r == (cnt_r - 4'd1))
  `PSFP_ASSERT_IMP(a_index_in_run, run_r, idx_r < cnt_r)

endmodule

### sv/particle_sensor_frame_parser_core.sv
// Top level of the particle sensor frame parser.
// The parser takes one received byte per cycle unless held off, and answers a
// frame on its final checksum byte: a good frame gives 13 words (15 in the long
// form), one per cycle from the output register while out_ready is high, and a
// bad length or checksum gives a single error word. The parser and the result
// sequencer are joined by a two-entry command queue, so bytes keep flowing while
// words drain. The word store has one write and one read port, so data bytes of
// the next frame wait while a good frame's words are still being read out, longer
// under output stalls. A full command queue holds off the low length byte and the
// low checksum byte.
module particle_sensor_frame_parser_core #(
  parameter int MAX_WORDS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic [1:0]  out_frame_status,
  output logic        out_has_env,
  output logic        out_last
);

  psfp_pkg::cmd_t push_cmd;
  psfp_pkg::cmd_t head_cmd;
  psfp_pkg::wr_t  store_wr;
  logic           push;
  logic           pop;
  logic           full;
  logic           nonempty;
  logic           run_done;

  psfp_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .run_done  (run_done),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd),
    .wr        (store_wr)
  );

  psfp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (push_cmd),
    .full    (full),
    .pop     (pop),
    .nonempty(nonempty),
    .dout    (head_cmd)
  );

  psfp_back #(
    .MAX_WORDS(MAX_WORDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (nonempty),
    .q_cmd           (head_cmd),
    .q_pop           (pop),
    .wr              (store_wr),
    .run_done        (run_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_frame_status(out_frame_status),
    .out_has_env     (out_has_env),
    .out_last        (out_last)
  );

endmodule

### tb/particle_sensor_frame_parser_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the particle sensor frame parser core.
module particle_sensor_frame_parser_core_test;

  localparam int WORD_CAP = 15;
  localparam int STREAM_BYTES = 420;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [2:0] P_HUNT   = 3'd0;
  localparam logic [2:0] P_HDR2   = 3'd1;
  localparam logic [2:0] P_LEN_HI = 3'd2;
  localparam logic [2:0] P_LEN_LO = 3'd3;
  localparam logic [2:0] P_DATA   = 3'd4;
  localparam logic [2:0] P_CHK_HI = 3'd5;
  localparam logic [2:0] P_CHK_LO = 3'd6;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] value;
    logic [1:0]  status;
    logic        env;
    logic        last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [3:0]  out_word_index;
  logic [15:0] out_word_value;
  logic [1:0]  out_frame_status;
  logic        out_has_env;
  logic        out_last;

  logic [2:0]   phase = P_HUNT;
  logic [5:0]   data_taken = '0;
  logic [5:0]   frame_len = '0;
  logic [15:0]  byte_sum = '0;
  logic [7:0]   high_hold = '0;
  logic [15:0]  word_buf [WORD_CAP];

  frame_word_t  expected_words [$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  int unsigned  ready_left = 0;
  bit           no_idle = 1'b0;

  particle_sensor_frame_parser_core #(
    .MAX_WORDS(WORD_CAP)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word_index(out_word_index),
    .out_word_value(out_word_value),
    .out_frame_status(out_frame_status),
    .out_has_env(out_has_env),
    .out_last(out_last)
  );

  initial forever #10 clk = ~clk;

  function automatic void expect_word(logic [3:0] idx, logic [15:0] value,
                                      logic [1:0] status, logic env, logic last);
    frame_word_t w;
    w.idx = idx;
    w.value = value;
    w.status = status;
    w.env = env;
    w.last = last;
    expected_words.push_back(w);
  endfunction

  // Advances the parser state by one accepted byte and queues the words it causes.
  function automatic void track_frame_byte(logic [7:0] b);
    logic [15:0] len;
    logic [15:0] rx_check;
    logic [4:0]  widx;
    logic        env;
    int          cnt;
    case (phase)
      P_HUNT: begin
        if (b == psfp_pkg::HDR_FIRST) begin
          phase = P_HDR2;
          byte_sum = 16'(psfp_pkg::HDR_FIRST);
        end
      end
      P_HDR2: begin
        if (b == psfp_pkg::HDR_SECOND) begin
          byte_sum = byte_sum + 16'(b);
          phase = P_LEN_HI;
        end else if (b == psfp_pkg::HDR_FIRST) begin
          byte_sum = 16'(psfp_pkg::HDR_FIRST);
        end else begin
          phase = P_HUNT;
        end
      end
      P_LEN_HI: begin
        high_hold = b;
        byte_sum = byte_sum + 16'(b);
        phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        len = {high_hold, b};
        byte_sum = byte_sum + 16'(b);
        if (len == psfp_pkg::LEN_SHORT || len == psfp_pkg::LEN_LONG) begin
          frame_len = len[5:0];
          data_taken = '0;
          phase = P_DATA;
        end else begin
          expect_word(4'd0, 16'd0, psfp_pkg::STAT_LEN_ERR, 1'b0, 1'b1);
          phase = P_HUNT;
        end
      end
      P_DATA: begin
        byte_sum = byte_sum + 16'(b);
        widx = data_taken[5:1];
        if (!data_taken[0]) begin
          high_hold = b;
        end else if (int'(widx) < WORD_CAP) begin
          word_buf[widx[3:0]] = {high_hold, b};
        end
        data_taken = data_taken + 6'd1;
        if (int'(data_taken) + 2 >= int'(frame_len)) begin
          phase = P_CHK_HI;
        end
      end
      P_CHK_HI: begin
        high_hold = b;
        phase = P_CHK_LO;
      end
      default: begin
        env = (frame_len == 6'(psfp_pkg::LEN_LONG));
        rx_check = {high_hold, b};
        if (rx_check == byte_sum) begin
          cnt = env ? psfp_pkg::WORDS_LONG : psfp_pkg::WORDS_SHORT;
          if (cnt > WORD_CAP) begin
            cnt = WORD_CAP;
          end
          for (int i = 0; i < cnt; i++) begin
            expect_word(4'(i), word_buf[i], psfp_pkg::STAT_OK, env, i == cnt - 1);
          end
        end else begin
          expect_word(4'd0, 16'd0, psfp_pkg::STAT_CHK_ERR, env, 1'b1);
        end
        phase = P_HUNT;
      end
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 25) return psfp_pkg::HDR_FIRST;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_frame_byte(b);
    bytes_sent++;
  endtask

  // A negative fill gives random data bytes.
  task automatic send_frame(input bit long_form, input bit bad_check, input int fill);
    logic [7:0]  frame [$];
    logic [15:0] len;
    logic [15:0] sum;
    len = long_form ? psfp_pkg::LEN_LONG : psfp_pkg::LEN_SHORT;
    frame = {psfp_pkg::HDR_FIRST, psfp_pkg::HDR_SECOND, len[15:8], len[7:0]};
    for (int i = 0; i < int'(len) - 2; i++) begin
      frame.push_back(fill < 0 ? rand_byte() : 8'(fill));
    end
    sum = '0;
    foreach (frame[i]) sum = sum + 16'(frame[i]);
    if (bad_check) begin
      sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    end
    frame.push_back(sum[15:8]);
    frame.push_back(sum[7:0]);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic send_bad_length();
    logic [15:0] len;
    len = 16'($urandom_range(0, 16'hFFFF));
    if (len == psfp_pkg::LEN_SHORT || len == psfp_pkg::LEN_LONG) begin
      len[0] = ~len[0];
    end
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic test_header_recovery();
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(8'h00);
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  task automatic test_bad_lengths();
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(8'h01);
    send_byte(psfp_pkg::LEN_SHORT[7:0]);
    send_byte(psfp_pkg::HDR_FIRST);
    send_byte(psfp_pkg::HDR_SECOND);
    send_byte(8'h00);
    send_byte(psfp_pkg::LEN_SHORT[7:0] + 8'd1);
  endtask

  task automatic test_good_frames();
    send_frame(1'b1, 1'b0, 8'hFF);
    send_frame(1'b0, 1'b0, 8'h00);
    repeat (4) send_frame($urandom_range(0, 1), 1'b0, -1);
  endtask

  task automatic test_checksum_errors();
    send_frame(1'b0, 1'b1, -1);
    send_frame(1'b1, 1'b1, -1);
    send_frame($urandom_range(0, 1), 1'b1, -1);
  endtask

  task automatic test_mixed_stream();
    int r;
    while (bytes_sent < STREAM_BYTES) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame($urandom_range(0, 1), 1'b0, -1);
      end else if (r < 75) begin
        send_frame($urandom_range(0, 1), 1'b1, -1);
      end else if (r < 85) begin
        send_bad_length();
      end else if (r < 92) begin
        send_byte(psfp_pkg::HDR_FIRST);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      ready_left <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got.idx = out_word_index;
      got.value = out_word_value;
      got.status = out_frame_status;
      got.env = out_has_env;
      got.last = out_last;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected word: index %0d value %h status %0d env %b last %b",
                   got.idx, got.value, got.status, got.env, got.last);
        end
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Word mismatch: expected index %0d value %h status %0d env %b last %b",
                     want.idx, want.value, want.status, want.env, want.last);
            $display("               got      index %0d value %h status %0d env %b last %b",
                     got.idx, got.value, got.status, got.env, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[particle_sensor_frame_parser_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_recovery();
    test_bad_lengths();
    test_good_frames();
    test_checksum_errors();
    test_mixed_stream();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[particle_sensor_frame_parser_core] OK");
    end else begin
      $display("[particle_sensor_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule
